// ===== hdl/kti_pkg.sv =====
// Shared types and constants of the keyframe track interpolator.
package kti_pkg;

  localparam logic [1:0] MODE_STEP  = 2'd0;
  localparam logic [1:0] MODE_LIN   = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  typedef enum logic [1:0] {
    CMD_INS  = 2'd0,
    CMD_REM  = 2'd1,
    CMD_MOVE = 2'd2,
    CMD_EVAL = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_DUP   = 3'd2,
    ST_NF    = 3'd3,
    ST_FULL  = 3'd4,
    ST_SAT   = 3'd5
  } stat_t;

  typedef enum logic [1:0] {
    PH_MAIN,
    PH_TGT,
    PH_INS
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SRD,
    S_SCMP,
    S_DISP,
    S_INS_CHK,
    S_INS_WR,
    S_REM_CHK,
    S_REM_WR,
    S_EV_LAST,
    S_EV_L,
    S_DIV,
    S_LMUL,
    S_LADD,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [23:0] kf;
    logic [23:0] tf;
    logic [31:0] kv;
    logic [31:0] ti;
    logic [31:0] to;
    logic [31:0] et;
    logic [23:0] ifr;
  } item_t;

  typedef struct packed {
    logic [23:0] frame;
    logic [31:0] value;
    logic [31:0] tin;
    logic [31:0] tout;
  } ent_t;

  typedef struct packed {
    logic [31:0] value;
    stat_t       status;
    logic [6:0]  count;
  } result_t;

endpackage

// ===== hdl/kti_fifo.sv =====
// Two-entry register queue used between the parts of the interpolator.
module kti_fifo import kti_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [1:0]   cnt_r, cnt_nxt, wpos;
  logic [W-1:0] d0_r, d1_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = d0_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign wpos    = cnt_r - {1'b0, do_pop};
  assign cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      d0_r <= d1_r;
    end
    if (do_push) begin
      if (wpos == 2'd0) begin
        d0_r <= wdata;
      end else begin
        d1_r <= wdata;
      end
    end
  end

endmodule

// ===== hdl/kti_front.sv =====
// Front end: decodes incoming words and queues them for the back end.
module kti_front import kti_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [23:0] in_knot_frame,
  input  logic [23:0] in_target_frame,
  input  logic [31:0] in_knot_value,
  input  logic [31:0] in_in_tangent,
  input  logic [31:0] in_out_tangent,
  input  logic [31:0] in_eval_time,
  input  logic        q_pop,
  output item_t       q_item,
  output logic        q_empty
);

  item_t dec;
  logic  round_up;

  // The integer frame of the time is truncated toward zero.
  assign round_up = in_eval_time[31] && (in_eval_time[7:0] != 8'd0);

  always_comb begin
    dec.cmd = cmd_t'(in_command);
    dec.kf  = in_knot_frame;
    dec.tf  = in_target_frame;
    dec.kv  = in_knot_value;
    dec.ti  = in_in_tangent;
    dec.to  = in_out_tangent;
    dec.et  = in_eval_time;
    dec.ifr = in_eval_time[31:8] + {23'd0, round_up};
  end

  kti_fifo #(.W($bits(item_t))) u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (dec),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

endmodule

// ===== hdl/kti_back.sv =====
// Back end: knot table, search and shift sequencer, divider and lerp unit.
module kti_back import kti_pkg::*; #(
  parameter int MAX_KNOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] mode,
  input  item_t      q_item,
  input  logic       q_empty,
  output logic       q_pop,
  output result_t    res,
  output logic       res_valid,
  input  logic       res_ready
);

  localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int CW = $clog2(MAX_KNOTS + 1);
  localparam int W  = 34;
  localparam int PW = W + FRAC_BITS + 2;
  localparam int DW = $clog2(FRAC_BITS + 1);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  item_t  item_r, item_nxt;
  ent_t   ent_r, ent_nxt;
  logic [23:0]    key_r, key_nxt;
  logic [CW-1:0]  idx_r, idx_nxt, pos_r, pos_nxt, spos_r, spos_nxt, cnt_r, cnt_nxt;
  logic           hit_r, hit_nxt;
  logic [31:0]    val_r, val_nxt;
  stat_t          stat_r, stat_nxt;
  logic [33:0]    rem_r, rem_nxt, den_r, den_nxt;
  logic [34:0]    rem2;
  logic [FRAC_BITS-1:0] q_r, q_nxt;
  logic [DW-1:0]  dc_r, dc_nxt;
  logic [1:0]     li_r, li_nxt, nl_r, nl_nxt;
  logic signed [W-1:0]  p0_r, p1_r, p2_r, p3_r, p0_nxt, p1_nxt, p2_nxt, p3_nxt;
  logic signed [W-1:0]  la, lb, sum;
  logic signed [PW-1:0] prod_r, prod_nxt, rnd;

  ent_t           mem [MAX_KNOTS];
  ent_t           rdata_r, wd;
  logic           rd_en, we;
  logic [AW-1:0]  rd_addr, wa;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    case (li_r)
      2'd0:    begin la = p0_r; lb = p1_r; end
      2'd1:    begin la = p1_r; lb = p2_r; end
      default: begin la = p2_r; lb = p3_r; end
    endcase
  end

  assign rem2 = {rem_r, 1'b0};
  assign rnd  = prod_r + (PW'(1) <<< (FRAC_BITS - 1));
  assign sum  = la + W'(rnd >>> FRAC_BITS);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (!q_empty) state_nxt = S_START;
      S_START: begin
        if (item_r.cmd == CMD_EVAL && cnt_r == '0) state_nxt = S_DONE;
        else state_nxt = S_SRD;
      end
      S_SRD:     state_nxt = (idx_r >= cnt_r) ? S_DISP : S_SCMP;
      S_SCMP: begin
        if ($signed(rdata_r.frame) >= $signed(key_r)) state_nxt = S_DISP;
        else state_nxt = S_SRD;
      end
      S_DISP: begin
        case (item_r.cmd)
          CMD_INS: begin
            if (hit_r || cnt_r >= CW'(MAX_KNOTS)) state_nxt = S_DONE;
            else state_nxt = S_INS_CHK;
          end
          CMD_REM:  state_nxt = hit_r ? S_REM_CHK : S_DONE;
          CMD_MOVE: begin
            case (phase_r)
              PH_MAIN: begin
                if (hit_r && item_r.tf != item_r.kf) state_nxt = S_SRD;
                else state_nxt = S_DONE;
              end
              PH_TGT:  state_nxt = hit_r ? S_DONE : S_REM_CHK;
              default: state_nxt = S_INS_CHK;
            endcase
          end
          default: begin
            if (hit_r || pos_r == '0) state_nxt = S_DONE;
            else if (pos_r == cnt_r) state_nxt = S_EV_LAST;
            else state_nxt = S_EV_L;
          end
        endcase
      end
      S_INS_CHK: state_nxt = (idx_r == pos_r) ? S_DONE : S_INS_WR;
      S_INS_WR:  state_nxt = S_INS_CHK;
      S_REM_CHK: begin
        if ((idx_r + 1'b1) >= cnt_r) begin
          state_nxt = (item_r.cmd == CMD_MOVE) ? S_SRD : S_DONE;
        end else begin
          state_nxt = S_REM_WR;
        end
      end
      S_REM_WR:  state_nxt = S_REM_CHK;
      S_EV_LAST: state_nxt = S_DONE;
      S_EV_L:    state_nxt = (mode == MODE_STEP) ? S_DONE : S_DIV;
      S_DIV:     if (dc_r == DW'(FRAC_BITS - 1)) state_nxt = S_LMUL;
      S_LMUL:    state_nxt = S_LADD;
      S_LADD:    state_nxt = (li_r + 2'd1 == nl_r && nl_r == 2'd1) ? S_DONE : S_LMUL;
      S_DONE:    if (res_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    item_nxt  = item_r;
    ent_nxt   = ent_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    spos_nxt  = spos_r;
    cnt_nxt   = cnt_r;
    hit_nxt   = hit_r;
    val_nxt   = val_r;
    stat_nxt  = stat_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    dc_nxt    = dc_r;
    li_nxt    = li_r;
    nl_nxt    = nl_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    p3_nxt    = p3_r;
    prod_nxt  = prod_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_r[AW-1:0];
    we        = 1'b0;
    wa        = idx_r[AW-1:0];
    wd        = rdata_r;
    res_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          val_nxt  = '0;
          stat_nxt = ST_OK;
        end
      end
      S_START: begin
        idx_nxt   = '0;
        phase_nxt = PH_MAIN;
        ent_nxt   = '{frame: item_r.kf, value: item_r.kv, tin: item_r.ti, tout: item_r.to};
        if (item_r.cmd == CMD_EVAL) begin
          key_nxt = item_r.ifr;
          if (cnt_r == '0) stat_nxt = ST_EMPTY;
        end else begin
          key_nxt = item_r.kf;
        end
      end
      S_SRD: begin
        if (idx_r >= cnt_r) begin
          pos_nxt = idx_r;
          hit_nxt = 1'b0;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_SCMP: begin
        if ($signed(rdata_r.frame) >= $signed(key_r)) begin
          pos_nxt = idx_r;
          hit_nxt = (rdata_r.frame == key_r);
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DISP: begin
        case (item_r.cmd)
          CMD_INS: begin
            if (hit_r) stat_nxt = ST_DUP;
            else if (cnt_r >= CW'(MAX_KNOTS)) stat_nxt = ST_FULL;
            else idx_nxt = cnt_r;
          end
          CMD_REM: begin
            if (hit_r) idx_nxt = pos_r;
            else stat_nxt = ST_NF;
          end
          CMD_MOVE: begin
            case (phase_r)
              PH_MAIN: begin
                if (!hit_r) begin
                  stat_nxt = ST_NF;
                end else if (item_r.tf != item_r.kf) begin
                  ent_nxt   = '{frame: item_r.tf, value: rdata_r.value,
                                tin: rdata_r.tin, tout: rdata_r.tout};
                  spos_nxt  = pos_r;
                  key_nxt   = item_r.tf;
                  phase_nxt = PH_TGT;
                  idx_nxt   = '0;
                end
              end
              PH_TGT: begin
                if (hit_r) stat_nxt = ST_DUP;
                else idx_nxt = spos_r;
              end
              default: idx_nxt = cnt_r;
            endcase
          end
          default: begin
            if (hit_r || pos_r == '0) begin
              val_nxt = rdata_r.value;
            end else if (pos_r == cnt_r) begin
              rd_en   = 1'b1;
              rd_addr = AW'(cnt_r - 1'b1);
            end else begin
              ent_nxt = rdata_r;
              rd_en   = 1'b1;
              rd_addr = AW'(pos_r - 1'b1);
            end
          end
        endcase
      end
      S_INS_CHK: begin
        if (idx_r == pos_r) begin
          we      = 1'b1;
          wa      = pos_r[AW-1:0];
          wd      = ent_r;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_r - 1'b1);
        end
      end
      S_INS_WR: begin
        we      = 1'b1;
        idx_nxt = idx_r - 1'b1;
      end
      S_REM_CHK: begin
        if ((idx_r + 1'b1) >= cnt_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          key_nxt   = item_r.tf;
          phase_nxt = PH_INS;
          idx_nxt   = '0;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_r + 1'b1);
        end
      end
      S_REM_WR: begin
        we      = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      S_EV_LAST: val_nxt = rdata_r.value;
      S_EV_L: begin
        val_nxt = rdata_r.value;
        rem_nxt = {{2{item_r.et[31]}}, item_r.et}
                - {{2{rdata_r.frame[23]}}, rdata_r.frame, 8'd0};
        den_nxt = {{2{ent_r.frame[23]}}, ent_r.frame, 8'd0}
                - {{2{rdata_r.frame[23]}}, rdata_r.frame, 8'd0};
        p0_nxt  = W'($signed(rdata_r.value));
        p1_nxt  = W'($signed(rdata_r.value)) + W'($signed(rdata_r.tout));
        p2_nxt  = W'($signed(ent_r.value)) + W'($signed(ent_r.tin));
        p3_nxt  = W'($signed(ent_r.value));
        nl_nxt  = 2'd3;
        if (mode == MODE_LIN) begin
          p1_nxt = W'($signed(ent_r.value));
          nl_nxt = 2'd1;
        end
        li_nxt = 2'd0;
        dc_nxt = '0;
        q_nxt  = '0;
      end
      S_DIV: begin
        if (rem2 >= {1'b0, den_r}) begin
          rem_nxt = 34'(rem2 - {1'b0, den_r});
          q_nxt   = {q_r[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = rem2[33:0];
          q_nxt   = {q_r[FRAC_BITS-2:0], 1'b0};
        end
        dc_nxt = dc_r + 1'b1;
      end
      S_LMUL: begin
        prod_nxt = PW'((W+1)'(lb) - (W+1)'(la)) * PW'($signed({1'b0, q_r}));
      end
      S_LADD: begin
        case (li_r)
          2'd0:    p0_nxt = sum;
          2'd1:    p1_nxt = sum;
          default: p2_nxt = sum;
        endcase
        if (li_r + 2'd1 == nl_r) begin
          li_nxt = 2'd0;
          nl_nxt = nl_r - 2'd1;
          if (nl_r == 2'd1) begin
            if (sum[W-1:31] != '0 && sum[W-1:31] != '1) begin
              stat_nxt = ST_SAT;
              val_nxt  = sum[W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
              val_nxt = sum[31:0];
            end
          end
        end else begin
          li_nxt = li_r + 2'd1;
        end
      end
      S_DONE:  res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    item_r  <= item_nxt;
    ent_r   <= ent_nxt;
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    spos_r  <= spos_nxt;
    hit_r   <= hit_nxt;
    val_r   <= val_nxt;
    stat_r  <= stat_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    q_r     <= q_nxt;
    dc_r    <= dc_nxt;
    li_r    <= li_nxt;
    nl_r    <= nl_nxt;
    p0_r    <= p0_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    p3_r    <= p3_nxt;
    prod_r  <= prod_nxt;
  end

  always_comb begin
    res.value  = val_r;
    res.status = stat_r;
    res.count  = 7'(cnt_r);
  end

endmodule

// ===== hdl/keyframe_track_interpolator_top.sv =====
// Top level of the keyframe track interpolator.
// Command words enter through a queue port: a word is taken on a clock edge with
// push high and full low. Results leave through a queue port: the oldest result is
// on the out_ ports while empty is low and is taken on an edge with pop high.
// A two-word queue at the input and another at the output decouple the sequencer
// from both neighbors, so a stalled receiver only stops the block once both queues
// fill. The mode register is written over the APB-style port at addresses 0 to 3.
// Each word is run by one sequencer on a single-port knot memory. A search reads
// and compares one knot at a time, an insert or remove shift moves one knot at a
// time. In linear and cubic Bezier mode an evaluate between knots adds FRAC_BITS
// divider steps and lerps of a multiply and an add state each: one lerp in linear
// mode, six in cubic Bezier mode; step mode uses neither.
// Synchronous reset empties the table and both queues and sets cubic Bezier mode.
module keyframe_track_interpolator_top import kti_pkg::*; #(
  parameter int MAX_KNOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [23:0] in_knot_frame,
  input  logic [23:0] in_target_frame,
  input  logic [31:0] in_knot_value,
  input  logic [31:0] in_in_tangent,
  input  logic [31:0] in_out_tangent,
  input  logic [31:0] in_eval_time,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_result_value,
  output logic [2:0]  out_status,
  output logic [6:0]  out_knot_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] mode_r;
  item_t      q_item;
  logic       q_empty, q_pop;
  result_t    res, ores;
  logic       res_valid, ofull;

  assign pready = 1'b1;
  assign prdata = {30'd0, mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      mode_r <= pwdata[1:0];
    end
  end

  kti_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_command      (in_command),
    .in_knot_frame   (in_knot_frame),
    .in_target_frame (in_target_frame),
    .in_knot_value   (in_knot_value),
    .in_in_tangent   (in_in_tangent),
    .in_out_tangent  (in_out_tangent),
    .in_eval_time    (in_eval_time),
    .q_pop           (q_pop),
    .q_item          (q_item),
    .q_empty         (q_empty)
  );

  kti_back #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .q_item    (q_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (!ofull)
  );

  kti_fifo #(.W($bits(result_t))) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res),
    .full  (ofull),
    .pop   (pop),
    .rdata (ores),
    .empty (empty)
  );

  assign out_result_value = ores.value;
  assign out_status       = ores.status;
  assign out_knot_count   = ores.count;

endmodule

// ===== sim/keyframe_track_interpolator_checker.sv =====
// Checker that predicts and compares every result word of the keyframe track interpolator.
`timescale 1ns / 1ps
module keyframe_track_interpolator_checker import kti_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  in_command,
  input  logic [23:0] in_knot_frame,
  input  logic [23:0] in_target_frame,
  input  logic [31:0] in_knot_value,
  input  logic [31:0] in_in_tangent,
  input  logic [31:0] in_out_tangent,
  input  logic [31:0] in_eval_time,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] out_result_value,
  input  logic [2:0]  out_status,
  input  logic [6:0]  out_knot_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  localparam int KNOTS = 64;
  localparam int FBITS = 16;

  longint knot_frm[KNOTS];
  longint knot_val[KNOTS];
  longint knot_tin[KNOTS];
  longint knot_tout[KNOTS];
  int knot_num;
  logic [1:0] mode;
  result_t expected_words[$];

  initial begin
    fail_count = 0;
    knot_num = 0;
    mode = 2'd2;
  end

  assign pending = expected_words.size();

  function automatic int first_at_or_after(longint f);
    int i;
    i = 0;
    while (i < knot_num && knot_frm[i] < f) i++;
    return i;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + (((b - a) * t + (64'sd1 <<< (FBITS - 1))) >>> FBITS);
  endfunction

  task automatic drop_knot(int i);
    for (int k = i; k < knot_num - 1; k++) begin
      knot_frm[k] = knot_frm[k + 1];
      knot_val[k] = knot_val[k + 1];
      knot_tin[k] = knot_tin[k + 1];
      knot_tout[k] = knot_tout[k + 1];
    end
    knot_num--;
  endtask

  task automatic add_knot(longint f, longint v, longint ti, longint to);
    int i;
    i = first_at_or_after(f);
    for (int k = knot_num; k > i; k--) begin
      knot_frm[k] = knot_frm[k - 1];
      knot_val[k] = knot_val[k - 1];
      knot_tin[k] = knot_tin[k - 1];
      knot_tout[k] = knot_tout[k - 1];
    end
    knot_frm[i] = f;
    knot_val[i] = v;
    knot_tin[i] = ti;
    knot_tout[i] = to;
    knot_num++;
  endtask

  task automatic eval_track(longint e, output longint res, output stat_t st);
    longint ifr, num, den, t, p0, p1, p2, p3, a, b, c, d, g;
    int i, l;
    st = ST_OK;
    res = 0;
    ifr = e / 256;
    i = first_at_or_after(ifr);
    if (knot_num == 0) begin
      st = ST_EMPTY;
    end else if (i < knot_num && knot_frm[i] == ifr) begin
      res = knot_val[i];
    end else if (i == 0) begin
      res = knot_val[0];
    end else if (i >= knot_num) begin
      res = knot_val[knot_num - 1];
    end else begin
      l = i - 1;
      num = e - knot_frm[l] * 256;
      den = (knot_frm[i] - knot_frm[l]) * 256;
      t = (num <<< FBITS) / den;
      if (mode == MODE_STEP) begin
        res = knot_val[l];
      end else if (mode == MODE_LIN) begin
        res = blend(knot_val[l], knot_val[i], t);
      end else begin
        p0 = knot_val[l];
        p1 = knot_val[l] + knot_tout[l];
        p2 = knot_val[i] + knot_tin[i];
        p3 = knot_val[i];
        a = blend(p0, p1, t);
        b = blend(p1, p2, t);
        c = blend(p2, p3, t);
        d = blend(a, b, t);
        g = blend(b, c, t);
        res = blend(d, g, t);
        if (res > 64'sd2147483647) begin
          res = 64'sd2147483647;
          st = ST_SAT;
        end else if (res < -64'sd2147483648) begin
          res = -64'sd2147483648;
          st = ST_SAT;
        end
      end
    end
  endtask

  task automatic predict_word();
    longint kf, tf, res;
    stat_t st;
    int i;
    result_t w;
    kf = longint'($signed(in_knot_frame));
    tf = longint'($signed(in_target_frame));
    st = ST_OK;
    res = 0;
    i = first_at_or_after(kf);
    case (cmd_t'(in_command))
      CMD_INS: begin
        if (i < knot_num && knot_frm[i] == kf) st = ST_DUP;
        else if (knot_num >= KNOTS) st = ST_FULL;
        else add_knot(kf, longint'($signed(in_knot_value)),
                      longint'($signed(in_in_tangent)), longint'($signed(in_out_tangent)));
      end
      CMD_REM: begin
        if (i < knot_num && knot_frm[i] == kf) drop_knot(i);
        else st = ST_NF;
      end
      CMD_MOVE: begin
        if (!(i < knot_num && knot_frm[i] == kf)) begin
          st = ST_NF;
        end else if (tf != kf) begin
          if (first_at_or_after(tf) < knot_num && knot_frm[first_at_or_after(tf)] == tf) begin
            st = ST_DUP;
          end else begin
            longint v, ti, to;
            v = knot_val[i];
            ti = knot_tin[i];
            to = knot_tout[i];
            drop_knot(i);
            add_knot(tf, v, ti, to);
          end
        end
      end
      default: eval_track(longint'($signed(in_eval_time)), res, st);
    endcase
    w.value = res[31:0];
    w.status = st;
    w.count = knot_num[6:0];
    expected_words.push_back(w);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      knot_num = 0;
      mode = 2'd2;
      expected_words.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expected word waiting");
          fail_count++;
        end else begin
          result_t w;
          w = expected_words.pop_front();
          if (out_result_value !== w.value) begin
            $error("result_value: expected %h, actual %h", w.value, out_result_value);
            fail_count++;
          end
          if (out_status !== w.status) begin
            $error("status: expected %0d, actual %0d", w.status, out_status);
            fail_count++;
          end
          if (out_knot_count !== w.count) begin
            $error("knot_count: expected %0d, actual %0d", w.count, out_knot_count);
            fail_count++;
          end
        end
      end
      if (push && !full) predict_word();
      if (psel && penable && pwrite && pready && paddr == 3'd0) mode = pwdata[1:0];
    end
  end
endmodule

// ===== sim/keyframe_track_interpolator_top_test.sv =====
// Testbench top that drives command words and register writes and reports the verdict.
`timescale 1ns / 1ps
module keyframe_track_interpolator_top_test;
  import kti_pkg::*;

  localparam int STALL_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] in_command = CMD_EVAL;
  logic [23:0] in_knot_frame = '0;
  logic [23:0] in_target_frame = '0;
  logic [31:0] in_knot_value = '0;
  logic [31:0] in_in_tangent = '0;
  logic [31:0] in_out_tangent = '0;
  logic [31:0] in_eval_time = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic full, empty, pready;
  logic [31:0] out_result_value, prdata;
  logic [2:0] out_status;
  logic [6:0] out_knot_count;
  int fail_count, pending;
  int idle_cycles = 0;
  int words_taken = 0;
  bit no_gaps = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  keyframe_track_interpolator_top DUT (.*);

  keyframe_track_interpolator_checker checker_inst (.*);

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("keyframe_track_interpolator_top_test: done, errors");
      $finish;
    end
  end

  initial begin
    @(posedge clk);
    wait (rst_n);
    forever begin
      int g;
      g = no_gaps ? 0 : $urandom_range(0, 18);
      if (words_taken == 200) begin
        pop <= 1'b0;
        repeat (700) @(posedge clk);
      end else if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      words_taken++;
    end
  end

  task automatic send_word(cmd_t c, logic [23:0] kf, logic [23:0] tf, logic [31:0] kv,
                           logic [31:0] ti, logic [31:0] to, logic [31:0] et);
    int g;
    g = no_gaps ? 0 : $urandom_range(0, 18);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    in_command <= c;
    in_knot_frame <= kf;
    in_target_frame <= tf;
    in_knot_value <= kv;
    in_in_tangent <= ti;
    in_out_tangent <= to;
    in_eval_time <= et;
    do @(posedge clk); while (full);
  endtask

  task automatic write_mode(logic [31:0] value);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_frame();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 24'($signed($urandom_range(0, 60)) - 30);
    if (r < 90) return $urandom_range(0, 1) ? 24'h800000 : 24'h7fffff;
    return 24'($urandom);
  endfunction

  function automatic logic [31:0] pick_time();
    if ($urandom_range(0, 9) < 8) return {pick_frame(), 8'($urandom)};
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    if (r < 6) return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
    return $urandom;
  endfunction

  task automatic send_random();
    int r;
    cmd_t c;
    r = $urandom_range(0, 99);
    c = r < 40 ? CMD_INS : r < 55 ? CMD_REM : r < 70 ? CMD_MOVE : CMD_EVAL;
    send_word(c, pick_frame(), pick_frame(), pick_value(), pick_value(), pick_value(),
              pick_time());
  endtask

  initial begin
    logic [31:0] modes[5];
    modes = '{32'd0, 32'd1, 32'd3, 32'hfffffffe, 32'd2};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(32'd2);
    send_word(CMD_EVAL, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(CMD_REM, 24'd5, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(CMD_MOVE, 24'd5, 24'd6, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(CMD_INS, 24'h800000, 24'd0, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'd0);
    send_word(CMD_INS, 24'h7fffff, 24'd0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'd0);
    send_word(CMD_INS, 24'd0, 24'd0, 32'h7fff0000, 32'h7fffffff, 32'h7fffffff, 32'd0);
    send_word(CMD_INS, 24'd4, 24'd0, 32'h7fff0000, 32'h7fffffff, 32'h7fffffff, 32'd0);
    send_word(CMD_INS, 24'd4, 24'd0, 32'd1, 32'd1, 32'd1, 32'd0);
    send_word(CMD_EVAL, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'h00000280);
    send_word(CMD_EVAL, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'h80000000);
    send_word(CMD_EVAL, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'h7fffffff);
    send_word(CMD_EVAL, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'hffffff80);
    send_word(CMD_EVAL, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'h00000400);
    send_word(CMD_MOVE, 24'd4, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(CMD_MOVE, 24'd4, 24'd4, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(CMD_MOVE, 24'd4, 24'hfffffd, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(CMD_MOVE, 24'd9, 24'd10, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(CMD_EVAL, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'hfffffe80);
    send_word(CMD_REM, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(CMD_REM, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    for (int k = 0; k < 64; k++)
      send_word(CMD_INS, 24'(100 + k), 24'd0, $urandom, $urandom, $urandom, 32'd0);
    send_word(CMD_INS, 24'd300, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(CMD_EVAL, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'h00006480);
    for (int p = 0; p < 5; p++) begin
      write_mode(modes[p]);
      for (int n = 0; n < 275; n++) begin
        if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_random();
      end
      no_gaps = 0;
    end
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("keyframe_track_interpolator_top_test: done, clean");
    end else begin
      $display("keyframe_track_interpolator_top_test: done, errors");
    end
    $finish;
  end
endmodule
